[rtl/buddy_block_allocator_defines.svh]
// ----------------------------------------------------------------------------
// Buddy block allocator assertion macros
// Shared clocking and reset for the concurrent checks of the allocator.
// ----------------------------------------------------------------------------
`ifndef BUDDY_BLOCK_ALLOCATOR_DEFINES_SVH
`define BUDDY_BLOCK_ALLOCATOR_DEFINES_SVH

// Check a property on every rising edge, off while reset is high.
`define BBA_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) prop) \
    else $error(msg);

// Check that a condition follows from a trigger in the next cycle.
`define BBA_ASSERT_NEXT(lbl, trig, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (trig) |=> (cons)) \
    else $error(msg);

`endif

[rtl/bba_pkg.sv]
// ----------------------------------------------------------------------------
// Buddy block allocator package
// Map entry codes, status codes, controller states and the control bundles.
// ----------------------------------------------------------------------------
`default_nettype none

package bba_pkg;

  localparam int unsigned MAX_POOL_ORDER_DEF  = 20;
  localparam int unsigned MIN_BLOCK_ORDER_DEF = 8;
  localparam int unsigned POOL_ORDER_FLOOR    = 15;
  localparam int unsigned POOL_ORDER_RESET    = 20;
  localparam int unsigned LANES               = 16;

  localparam logic CFG_POOL_ORDER = 1'b0;
  localparam logic CFG_POOL_BASE  = 1'b1;

  localparam logic REQ_ALLOC = 1'b0;
  localparam logic REQ_FREE  = 1'b1;

  localparam logic [1:0] STAT_OK        = 2'd0;
  localparam logic [1:0] STAT_NO_SPACE  = 2'd1;
  localparam logic [1:0] STAT_TOO_LARGE = 2'd2;
  localparam logic [1:0] STAT_BAD_FREE  = 2'd3;

  typedef enum logic [1:0] {
    BLK_NONE = 2'd0,
    BLK_FREE = 2'd1,
    BLK_USED = 2'd2,
    BLK_RSVD = 2'd3
  } blk_t;

  typedef enum logic [3:0] {
    S_CLEAR,
    S_IDLE,
    S_DISPATCH,
    S_SCAN,
    S_SPLIT_RDN,
    S_SPLIT_WRN,
    S_SPLIT_RDC,
    S_SPLIT_WRC,
    S_USE_RD,
    S_USE_WR,
    S_FREE_CHK,
    S_MERGE_RD,
    S_MERGE_WR,
    S_DONE
  } state_t;

  typedef enum logic [4:0] {
    OP_NONE,
    OP_CLEAR,
    OP_LOAD,
    OP_SCAN_INIT,
    OP_SCAN_NEXT,
    OP_FOUND,
    OP_RD_NODE,
    OP_RD_CHILD,
    OP_WR_NODE_NONE,
    OP_WR_CHILD_FREE,
    OP_WR_NODE_USED,
    OP_FREE_INIT,
    OP_FREE_NEXT,
    OP_FREE_HIT,
    OP_MERGE_UP,
    OP_WR_NODE_FREE,
    OP_RES_TOOBIG,
    OP_RES_NOSPACE,
    OP_RES_BADFREE,
    OP_PUSH
  } dp_op_t;

  typedef struct packed {
    logic relayout;
    logic clr_last;
    logic req_free;
    logic too_large;
    logic out_of_pool;
    logic hit;
    logic at_target;
    logic next_at_target;
    logic scan_last;
    logic d_is_one;
    logic lane_nz;
    logic free_ok;
    logic at_max_depth;
    logic merge_go;
  } dp_status_t;

endpackage

`default_nettype wire

[rtl/bba_datapath.sv]
// ----------------------------------------------------------------------------
// Buddy block allocator datapath
// Block map memory, request registers, tree walk registers and result stage.
// ----------------------------------------------------------------------------
`default_nettype none

module bba_datapath #(
  parameter int unsigned MAX_POOL_ORDER  = bba_pkg::MAX_POOL_ORDER_DEF,
  parameter int unsigned MIN_BLOCK_ORDER = bba_pkg::MIN_BLOCK_ORDER_DEF
) (
  input  wire logic               clk,
  input  wire logic               rst,
  input  wire logic               cfg_we,
  input  wire logic               cfg_index,
  input  wire logic [31:0]        cfg_data,
  input  wire logic               req_type,
  input  wire logic [19:0]        request_bytes,
  input  wire logic [31:0]        free_address,
  input  wire bba_pkg::dp_op_t    op,
  output bba_pkg::dp_status_t     stat,
  output logic [1:0]              res_status,
  output logic [31:0]             res_address,
  output logic [4:0]              res_order
);
  import bba_pkg::*;

  localparam int unsigned IW   = MAX_POOL_ORDER - MIN_BLOCK_ORDER + 1;
  localparam int unsigned RW   = (IW > 4) ? IW - 4 : 1;
  localparam int unsigned ROWS = 1 << (IW - 4);

  logic [31:0]    mem [ROWS];
  logic [31:0]    rdata;

  logic [4:0]     pool_order;
  logic [31:0]    pool_base;
  logic [RW-1:0]  clr_row;

  logic           req_free;
  logic [4:0]     req_k;
  logic [31:0]    req_addr;
  logic [31:0]    off;
  logic [4:0]     d;
  logic [4:0]     target;
  logic [IW-1:0]  n;
  logic [RW-1:0]  scan_row;

  logic [1:0]     pend_status;
  logic [31:0]    pend_addr;
  logic [4:0]     pend_order;

  logic           relayout;
  logic [4:0]     ceil_k;
  logic [4:0]     md;
  logic [IW-1:0]  child;
  logic [IW-1:0]  n_next_free;
  logic           hit;
  logic [3:0]     hit_lane;
  logic [IW-1:0]  hit_node;
  logic           wr_en;
  logic [RW-1:0]  wr_row;
  logic [31:0]    wr_data;
  logic           rd_en;
  logic [RW-1:0]  rd_row;
  logic [31:0]    node_off;

  function automatic logic [4:0] clamp_order(input logic [4:0] v);
    logic [4:0] p;
    p = v;
    if (p > 5'(MAX_POOL_ORDER)) p = 5'(MAX_POOL_ORDER);
    if (p < 5'(POOL_ORDER_FLOOR)) p = 5'(POOL_ORDER_FLOOR);
    return p;
  endfunction

  function automatic logic [31:0] init_row(input logic [RW-1:0] r);
    logic [IW-1:0] idx;
    logic [31:0]   w;
    w = '0;
    for (int l = 0; l < 16; l++) begin
      idx = IW'((int'(r) << 4) + l);
      if (idx == IW'(16)) begin
        w[2*l +: 2] = BLK_RSVD;
      end else if (idx == IW'(3) || idx == IW'(5) || idx == IW'(9) || idx == IW'(17)) begin
        w[2*l +: 2] = BLK_FREE;
      end
    end
    return w;
  endfunction

  function automatic logic [RW-1:0] first_row(input logic [4:0] dd);
    if (dd < 5'd4) return '0;
    return RW'(32'd1 << (dd - 5'd4));
  endfunction

  function automatic logic [RW-1:0] last_row(input logic [4:0] dd);
    if (dd < 5'd4) return '0;
    return RW'((32'd1 << (dd - 5'd3)) - 32'd1);
  endfunction

  function automatic logic [RW-1:0] row_of(input logic [IW-1:0] idx);
    return RW'(idx >> 4);
  endfunction

  function automatic blk_t get_lane(input logic [31:0] w, input logic [3:0] l);
    return blk_t'(w[{l, 1'b0} +: 2]);
  endfunction

  function automatic logic [31:0] set_lane(input logic [31:0] w, input logic [3:0] l,
                                           input blk_t v);
    logic [31:0] r;
    r = w;
    r[{l, 1'b0} +: 2] = v;
    return r;
  endfunction

  assign relayout = cfg_we && (cfg_index == CFG_POOL_ORDER);
  assign md       = pool_order - 5'(MIN_BLOCK_ORDER);
  assign child    = {n[IW-2:0], 1'b1};
  assign n_next_free = {n[IW-2:0], off[pool_order - d - 5'd1]};
  assign hit_node = IW'({scan_row, hit_lane});
  assign node_off = 32'(n) & ~(32'd1 << d);

  // round the request up to a power of two, floor at the minimum block
  always_comb begin
    logic [19:0] m;
    m = request_bytes - 20'd1;
    ceil_k = 5'(MIN_BLOCK_ORDER);
    if ({1'b0, request_bytes} > (21'd1 << MIN_BLOCK_ORDER)) begin
      for (int i = 0; i < 20; i++) begin
        if (m[i]) ceil_k = 5'(i + 1);
      end
    end
  end

  // lowest free lane of the row, limited to the lanes of depth d
  always_comb begin
    hit      = 1'b0;
    hit_lane = '0;
    for (int l = 15; l >= 0; l--) begin
      if (((d >= 5'd4) || ((l >> d) == 1)) && (rdata[2*l +: 2] == BLK_FREE)) begin
        hit      = 1'b1;
        hit_lane = 4'(l);
      end
    end
  end

  always_comb begin
    stat.relayout       = relayout;
    stat.clr_last       = (clr_row == RW'(ROWS - 1));
    stat.req_free       = req_free;
    stat.too_large      = (req_k >= pool_order);
    stat.out_of_pool    = ({1'b0, off} >= (33'd1 << pool_order));
    stat.hit            = hit;
    stat.at_target      = (d == target);
    stat.next_at_target = ((d + 5'd1) == target);
    stat.scan_last      = (scan_row == last_row(d));
    stat.d_is_one       = (d == 5'd1);
    stat.lane_nz        = (get_lane(rdata, n[3:0]) != BLK_NONE);
    stat.free_ok        = (get_lane(rdata, n[3:0]) == BLK_USED) &&
                          ((off & ~(32'hFFFF_FFFF << (pool_order - d))) == 32'd0);
    stat.at_max_depth   = (d == md);
    stat.merge_go       = (d > 5'd1) && (get_lane(rdata, n[3:0] ^ 4'd1) == BLK_FREE);
  end

  always_comb begin
    wr_en   = 1'b0;
    wr_row  = row_of(n);
    wr_data = rdata;
    rd_en   = 1'b0;
    rd_row  = row_of(n);
    case (op)
      OP_CLEAR: begin
        wr_en   = 1'b1;
        wr_row  = clr_row;
        wr_data = init_row(clr_row);
      end
      OP_WR_NODE_NONE: begin
        wr_en   = 1'b1;
        wr_data = set_lane(rdata, n[3:0], BLK_NONE);
      end
      OP_WR_CHILD_FREE: begin
        wr_en   = 1'b1;
        wr_row  = row_of(child);
        wr_data = set_lane(rdata, child[3:0], BLK_FREE);
      end
      OP_WR_NODE_USED: begin
        wr_en   = 1'b1;
        wr_data = set_lane(rdata, n[3:0], BLK_USED);
      end
      OP_WR_NODE_FREE: begin
        wr_en   = 1'b1;
        wr_data = set_lane(rdata, n[3:0], BLK_FREE);
      end
      OP_MERGE_UP: begin
        wr_en   = 1'b1;
        wr_data = set_lane(set_lane(rdata, n[3:0], BLK_NONE), n[3:0] ^ 4'd1, BLK_NONE);
      end
      OP_SCAN_INIT: begin
        rd_en  = 1'b1;
        rd_row = first_row(pool_order - req_k);
      end
      OP_SCAN_NEXT: begin
        rd_en  = 1'b1;
        rd_row = stat.scan_last ? first_row(d - 5'd1) : scan_row + RW'(1);
      end
      OP_FREE_INIT: begin
        rd_en  = 1'b1;
        rd_row = '0;
      end
      OP_FREE_NEXT: begin
        rd_en  = 1'b1;
        rd_row = row_of(n_next_free);
      end
      OP_RD_NODE: begin
        rd_en = 1'b1;
      end
      OP_RD_CHILD: begin
        rd_en  = 1'b1;
        rd_row = row_of(child);
      end
      default: begin
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (wr_en) mem[wr_row] <= wr_data;
    if (rd_en) rdata <= mem[rd_row];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pool_order <= clamp_order(5'(POOL_ORDER_RESET));
      pool_base  <= '0;
      clr_row    <= '0;
    end else begin
      if (relayout) begin
        pool_order <= clamp_order(cfg_data[4:0]);
        clr_row    <= '0;
      end else if (op == OP_CLEAR) begin
        clr_row <= clr_row + RW'(1);
      end
      if (cfg_we && (cfg_index == CFG_POOL_BASE)) pool_base <= cfg_data;
    end
  end

  always_ff @(posedge clk) begin
    case (op)
      OP_LOAD: begin
        req_free <= (req_type == REQ_FREE);
        req_k    <= ceil_k;
        req_addr <= free_address;
        off      <= free_address - pool_base;
      end
      OP_SCAN_INIT: begin
        d        <= pool_order - req_k;
        target   <= pool_order - req_k;
        scan_row <= first_row(pool_order - req_k);
      end
      OP_SCAN_NEXT: begin
        if (stat.scan_last) begin
          d        <= d - 5'd1;
          scan_row <= first_row(d - 5'd1);
        end else begin
          scan_row <= scan_row + RW'(1);
        end
      end
      OP_FOUND: n <= hit_node;
      OP_WR_CHILD_FREE: begin
        n <= {n[IW-2:0], 1'b0};
        d <= d + 5'd1;
      end
      OP_WR_NODE_USED: begin
        pend_status <= STAT_OK;
        pend_addr   <= pool_base + (node_off << req_k);
        pend_order  <= req_k;
      end
      OP_FREE_INIT: begin
        d <= '0;
        n <= IW'(1);
      end
      OP_FREE_NEXT: begin
        d <= d + 5'd1;
        n <= n_next_free;
      end
      OP_FREE_HIT: begin
        pend_status <= STAT_OK;
        pend_addr   <= req_addr;
        pend_order  <= pool_order - d;
      end
      OP_MERGE_UP: begin
        n <= n >> 1;
        d <= d - 5'd1;
      end
      OP_RES_TOOBIG: begin
        pend_status <= STAT_TOO_LARGE;
        pend_addr   <= '0;
        pend_order  <= req_k;
      end
      OP_RES_NOSPACE: begin
        pend_status <= STAT_NO_SPACE;
        pend_addr   <= '0;
        pend_order  <= req_k;
      end
      OP_RES_BADFREE: begin
        pend_status <= STAT_BAD_FREE;
        pend_addr   <= req_addr;
        pend_order  <= '0;
      end
      OP_PUSH: begin
        res_status  <= pend_status;
        res_address <= pend_addr;
        res_order   <= pend_order;
      end
      default: begin
      end
    endcase
  end

endmodule

`default_nettype wire

[rtl/bba_ctrl.sv]
// ----------------------------------------------------------------------------
// Buddy block allocator controller
// Sequences map clearing, the allocate search and split, and the free merge.
// ----------------------------------------------------------------------------
`default_nettype none
`include "buddy_block_allocator_defines.svh"

module bba_ctrl (
  input  wire logic                clk,
  input  wire logic                rst,
  input  wire logic                s_tvalid,
  output logic                     s_tready,
  output logic                     m_tvalid,
  input  wire logic                m_tready,
  input  wire bba_pkg::dp_status_t stat,
  output bba_pkg::dp_op_t          op
);
  import bba_pkg::*;

  state_t state, state_next;
  logic   out_valid_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= S_CLEAR;
      m_tvalid <= 1'b0;
    end else begin
      state    <= state_next;
      m_tvalid <= out_valid_next;
    end
  end

  always_comb begin
    state_next = state;
    op         = OP_NONE;
    s_tready   = 1'b0;
    case (state)
      S_CLEAR: begin
        op = OP_CLEAR;
        if (stat.clr_last) state_next = S_IDLE;
      end
      S_IDLE: begin
        s_tready = 1'b1;
        if (s_tvalid) begin
          op         = OP_LOAD;
          state_next = S_DISPATCH;
        end
      end
      S_DISPATCH: begin
        if (stat.req_free) begin
          if (stat.out_of_pool) begin
            op         = OP_RES_BADFREE;
            state_next = S_DONE;
          end else begin
            op         = OP_FREE_INIT;
            state_next = S_FREE_CHK;
          end
        end else if (stat.too_large) begin
          op         = OP_RES_TOOBIG;
          state_next = S_DONE;
        end else begin
          op         = OP_SCAN_INIT;
          state_next = S_SCAN;
        end
      end
      S_SCAN: begin
        if (stat.hit) begin
          op         = OP_FOUND;
          state_next = stat.at_target ? S_USE_RD : S_SPLIT_RDN;
        end else if (stat.scan_last && stat.d_is_one) begin
          op         = OP_RES_NOSPACE;
          state_next = S_DONE;
        end else begin
          op = OP_SCAN_NEXT;
        end
      end
      S_SPLIT_RDN: begin
        op         = OP_RD_NODE;
        state_next = S_SPLIT_WRN;
      end
      S_SPLIT_WRN: begin
        op         = OP_WR_NODE_NONE;
        state_next = S_SPLIT_RDC;
      end
      S_SPLIT_RDC: begin
        op         = OP_RD_CHILD;
        state_next = S_SPLIT_WRC;
      end
      S_SPLIT_WRC: begin
        op         = OP_WR_CHILD_FREE;
        state_next = stat.next_at_target ? S_USE_RD : S_SPLIT_RDN;
      end
      S_USE_RD: begin
        op         = OP_RD_NODE;
        state_next = S_USE_WR;
      end
      S_USE_WR: begin
        op         = OP_WR_NODE_USED;
        state_next = S_DONE;
      end
      S_FREE_CHK: begin
        if (stat.lane_nz) begin
          if (stat.free_ok) begin
            op         = OP_FREE_HIT;
            state_next = S_MERGE_WR;
          end else begin
            op         = OP_RES_BADFREE;
            state_next = S_DONE;
          end
        end else if (stat.at_max_depth) begin
          op         = OP_RES_BADFREE;
          state_next = S_DONE;
        end else begin
          op = OP_FREE_NEXT;
        end
      end
      S_MERGE_RD: begin
        op         = OP_RD_NODE;
        state_next = S_MERGE_WR;
      end
      S_MERGE_WR: begin
        if (stat.merge_go) begin
          op         = OP_MERGE_UP;
          state_next = S_MERGE_RD;
        end else begin
          op         = OP_WR_NODE_FREE;
          state_next = S_DONE;
        end
      end
      S_DONE: begin
        if (!m_tvalid || m_tready) begin
          op         = OP_PUSH;
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
    // a pool order write restarts the layout pass
    if (stat.relayout) state_next = S_CLEAR;
  end

  always_comb begin
    out_valid_next = m_tvalid && !m_tready;
    if (op == OP_PUSH) out_valid_next = 1'b1;
  end

  `BBA_ASSERT_NEXT(a_busy_after_accept, s_tvalid && s_tready, !s_tready,
                   "input accepted while a request is still in progress")
  `BBA_ASSERT(a_push_slot_free, (op == OP_PUSH) |-> (!m_tvalid || m_tready),
              "result pushed over an untaken result")
  `BBA_ASSERT_NEXT(a_relayout_clears, stat.relayout, state == S_CLEAR,
                   "pool order write did not start the layout pass")

endmodule

`default_nettype wire

[rtl/buddy_block_allocator.sv]
// Allocate: dispatch, a scan of the 16-entry map rows, a node and a child read and write
// per split level, then a read and write that mark the block used. Free: a walk down the
// tree levels, then the merges. Too-large and out-of-pool errors end at dispatch.
// One request at a time; the map memory port and the row scan set the rate.
// The next request is taken while a finished result waits on the output.
// Bad frees end the walk. Reset and every pool_order write run a layout pass
// over the map, one row per cycle, with s_tready low.
// ----------------------------------------------------------------------------
// Buddy block allocator
// Binary buddy allocator over a configurable pool with a packed block map.
// ----------------------------------------------------------------------------
`default_nettype none

module buddy_block_allocator #(
  parameter int unsigned MAX_POOL_ORDER  = bba_pkg::MAX_POOL_ORDER_DEF,
  parameter int unsigned MIN_BLOCK_ORDER = bba_pkg::MIN_BLOCK_ORDER_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst,
  // configuration write port: 0 pool_order, 1 pool_base
  input  wire logic        cfg_we,
  input  wire logic        cfg_index,
  input  wire logic [31:0] cfg_data,
  // request stream
  input  wire logic        s_tvalid,
  output logic             s_tready,
  input  wire logic [55:0] s_tdata,   // [19:0] request_bytes, [51:20] free_address
  input  wire logic        s_tuser,   // [0] req_type
  // result stream
  output logic             m_tvalid,
  input  wire logic        m_tready,
  output logic [39:0]      m_tdata,   // [31:0] block_address, [36:32] block_order
  output logic [1:0]       m_tuser    // [1:0] status
);
  import bba_pkg::*;

  dp_op_t      op;
  dp_status_t  stat;
  logic [31:0] res_address;
  logic [4:0]  res_order;

  // Controller: owns the handshake and walks the tree one map row per step.
  bba_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .stat     (stat),
    .op       (op)
  );

  // Datapath: block map (16 two-bit entries per word), request latch,
  // node and depth registers, and the registered result stage.
  bba_datapath #(
    .MAX_POOL_ORDER  (MAX_POOL_ORDER),
    .MIN_BLOCK_ORDER (MIN_BLOCK_ORDER)
  ) u_dp (
    .clk           (clk),
    .rst           (rst),
    .cfg_we        (cfg_we),
    .cfg_index     (cfg_index),
    .cfg_data      (cfg_data),
    .req_type      (s_tuser),
    .request_bytes (s_tdata[19:0]),
    .free_address  (s_tdata[51:20]),
    .op            (op),
    .stat          (stat),
    .res_status    (m_tuser),
    .res_address   (res_address),
    .res_order     (res_order)
  );

  // pack the result beat; pad bits stay zero
  assign m_tdata = {3'b000, res_order, res_address};

endmodule

`default_nettype wire
